// ----- rtl/core/ecbu_pkg.sv -----
// ----------------------------------------------------------------------------
// ecbu_pkg
// Shared types, constants and the arctangent table of the camera basis update.
// ----------------------------------------------------------------------------
package ecbu_pkg;

  // action codes of an input transaction
  typedef enum logic [2:0] {
    ACT_ROTATE    = 3'd0,
    ACT_SCROLL    = 3'd1,
    ACT_MOVE      = 3'd2,
    ACT_SET_YAW   = 3'd3,
    ACT_SET_PITCH = 3'd4,
    ACT_SET_POS   = 3'd5
  } ecbu_action_e;

  // configuration register indexes
  typedef enum logic {
    CFG_MOUSE_GAIN  = 1'b0,
    CFG_PITCH_LIMIT = 1'b1
  } ecbu_cfg_e;

  typedef struct packed {
    logic        [2:0]  action;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] angle;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } ecbu_in_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } ecbu_out_t;

  // angles in Q9.7 degrees
  localparam logic signed [15:0] DEG90      = 16'sd11520;
  localparam logic signed [16:0] DEG180     = 17'sd23040;
  localparam logic signed [21:0] WRAP_HALF  = 22'sd23040;
  localparam logic signed [21:0] WRAP_FULL  = 22'sd46080;
  localparam logic        [13:0] LIMIT_MAX  = 14'd11520;

  // gain-corrected 1.0 in Q2.30
  localparam logic signed [31:0] CORDIC_ONE = 32'sd652032874;
  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;

  // reset values
  localparam logic        [15:0] GAIN_RST   = 16'd6554;
  localparam logic        [13:0] LIMIT_RST  = 14'd11392;
  localparam logic signed [15:0] YAW_RST    = -16'sd11520;
  localparam logic signed [31:0] POS_RST_Y  = 32'sd655360;
  localparam logic signed [31:0] POS_RST_Z  = 32'sd5242880;

  // normalize datapath widths
  localparam int unsigned SUM_W  = 50;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned NORM_W = 24;
  localparam int unsigned QUO_W  = 16;

  // atan(2^-i) in degrees scaled by 2^16
  function automatic logic [21:0] atan_val(input logic [4:0] idx);
    logic [21:0] r;
    case (idx)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/ecbu_mul.sv -----
// ----------------------------------------------------------------------------
// ecbu_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module ecbu_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  logic signed [63:0] p_d;
  logic signed [63:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ----- rtl/core/ecbu_cordic.sv -----
// ----------------------------------------------------------------------------
// ecbu_cordic
// Iterative rotation-mode cordic, one micro-rotation per cycle, cos and sin.
// ----------------------------------------------------------------------------
module ecbu_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] angle_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import ecbu_pkg::*;

  localparam int unsigned CntW = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(STEPS - 1);

  logic               busy_q;
  logic               done_q;
  logic               flip_q;
  logic [CntW-1:0]    cnt_q;
  logic signed [31:0] x_q;
  logic signed [31:0] y_q;
  logic signed [25:0] z_q;

  logic signed [16:0] red;
  logic               flip;
  logic signed [31:0] dx;
  logic signed [31:0] dy;
  logic signed [25:0] at;

  // fold the angle into [-90, 90]
  always_comb begin
    red  = 17'(angle_i);
    flip = 1'b0;
    if (angle_i > DEG90) begin
      red  = 17'(angle_i) - DEG180;
      flip = 1'b1;
    end else if (angle_i < -DEG90) begin
      red  = 17'(angle_i) + DEG180;
      flip = 1'b1;
    end
  end

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = 26'(atan_val(5'(cnt_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      flip_q <= 1'b0;
      cnt_q  <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        flip_q <= flip;
        cnt_q  <= '0;
        x_q    <= CORDIC_ONE;
        y_q    <= '0;
        z_q    <= {red, 9'b0};
      end else if (busy_q) begin
        if (!z_q[25]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule

// ----- rtl/core/ecbu_isqrt.sv -----
// ----------------------------------------------------------------------------
// ecbu_isqrt
// Bit-pair integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module ecbu_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ecbu_pkg::SUM_W-1:0]    n_i,
  output logic                          done_o,
  output logic [ecbu_pkg::LEN_W-1:0]    root_o
);
  import ecbu_pkg::*;

  localparam logic [SUM_W-1:0] BitTop = {2'b01, {(SUM_W - 2){1'b0}}};

  logic             busy_q;
  logic             done_q;
  logic [SUM_W-1:0] n_q;
  logic [SUM_W-1:0] res_q;
  logic [SUM_W-1:0] bit_q;
  logic [SUM_W-1:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
      res_q  <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        n_q    <= n_i;
        res_q  <= '0;
        bit_q  <= BitTop;
      end else if (busy_q) begin
        if (n_q >= trial) begin
          n_q   <= n_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[LEN_W-1:0];

endmodule

// ----- rtl/core/ecbu_div.sv -----
// ----------------------------------------------------------------------------
// ecbu_div
// Restoring divider for one normalized component, rounded to Q1.14.
// ----------------------------------------------------------------------------
module ecbu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ecbu_pkg::NORM_W-1:0] mag_i,
  input  logic [ecbu_pkg::LEN_W-1:0]  len_i,
  output logic                        done_o,
  output logic [ecbu_pkg::QUO_W-1:0]  quo_o
);
  import ecbu_pkg::*;

  localparam int unsigned NumW = NORM_W + QUO_W;
  localparam int unsigned DenW = LEN_W + 1;

  logic             busy_q;
  logic             done_q;
  logic [3:0]       cnt_q;
  logic [DenW-1:0]  rem_q;
  logic [DenW-1:0]  den_q;
  logic [QUO_W-1:0] low_q;
  logic [QUO_W-1:0] quo_q;

  logic [NumW-1:0]  num;
  logic [DenW:0]    part;
  logic             ge;

  // (mag * 32768 + len) / (2 * len), rounding half away
  assign num  = NumW'({mag_i, 15'b0}) + NumW'(len_i);
  assign part = {rem_q, low_q[QUO_W-1]};
  assign ge   = (part >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      low_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= DenW'(num[NumW-1:QUO_W]);
        low_q  <= num[QUO_W-1:0];
        den_q  <= {len_i, 1'b0};
        quo_q  <= '0;
      end else if (busy_q) begin
        if (ge) begin
          rem_q <= DenW'(part - {1'b0, den_q});
        end else begin
          rem_q <= part[DenW-1:0];
        end
        low_q <= low_q << 1;
        quo_q <= {quo_q[QUO_W-2:0], ge};
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 4'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/euler_camera_basis_update.sv -----
// ----------------------------------------------------------------------------
// euler_camera_basis_update
// Fly camera state: yaw, pitch, position and the unit front/right/up basis.
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid_i/in_ready_o/in_data_i) takes one action per
//   transaction: rotate, scroll, move, set yaw, set pitch or set position
//   out channel (out_valid_o/out_ready_i/out_data_o) returns one result per
//   input transaction: the three basis vectors and the position after it
//   cfg port writes mouse gain (index 0) or pitch limit (index 1), one per write
// sequencing
//   set position and unused codes go straight to ST_DONE; move passes ST_MOVE;
//   scroll runs a multiply and an add for each axis; angle actions run two
//   cordic passes, then three normalize passes, each a one-bit-per-cycle
//   shift search, a square root and three divides, the products taken on one
//   shared multiplier
//   one transaction in flight; in_ready_o is high only while idle
// reset
//   yaw -90 deg, pitch 0, position (0, 10, 80), front (0,0,-1),
//   right (1,0,0), up (0,1,0), gain 0.1, limit 89 deg
// stall
//   a finished result sits in the output register; the next transaction is
//   accepted meanwhile, but its result waits until the register is free
// ----------------------------------------------------------------------------
module euler_camera_basis_update #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ecbu_pkg::ecbu_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecbu_pkg::ecbu_out_t out_data_o
);
  import ecbu_pkg::*;

  typedef enum logic [24:0] {
    ST_IDLE      = 25'h0000001,
    ST_ROT_X     = 25'h0000002,
    ST_ROT_Y     = 25'h0000004,
    ST_ROT_P     = 25'h0000008,
    ST_WRAP      = 25'h0000010,
    ST_SCR_MUL   = 25'h0000020,
    ST_SCR_ADD   = 25'h0000040,
    ST_MOVE      = 25'h0000080,
    ST_COR_GO    = 25'h0000100,
    ST_COR_WAIT  = 25'h0000200,
    ST_FR_MUL    = 25'h0000400,
    ST_FR_LOAD   = 25'h0000800,
    ST_N_ABS     = 25'h0001000,
    ST_N_SHIFT   = 25'h0002000,
    ST_SQ_MUL    = 25'h0004000,
    ST_SQ_ACC    = 25'h0008000,
    ST_SQRT_GO   = 25'h0010000,
    ST_SQRT_WAIT = 25'h0020000,
    ST_DIV_GO    = 25'h0040000,
    ST_DIV_WAIT  = 25'h0080000,
    ST_N_END     = 25'h0100000,
    ST_R_LOAD    = 25'h0200000,
    ST_UP_MUL    = 25'h0400000,
    ST_UP_ACC    = 25'h0800000,
    ST_DONE      = 25'h1000000
  } ecbu_state_e;

  // which basis vector the normalize pass is producing
  typedef enum logic [1:0] {
    SEL_FRONT = 2'd0,
    SEL_RIGHT = 2'd1,
    SEL_UP    = 2'd2
  } ecbu_sel_e;

  ecbu_state_e        state_q;
  ecbu_sel_e          sel_q;
  logic [2:0]         k_q;
  logic               cor_pitch_q;
  logic               deg_q;
  ecbu_in_t           req_q;
  logic [15:0]        gain_q;
  logic [13:0]        limit_q;
  logic signed [15:0] yaw_q;
  logic signed [15:0] pitch_q;
  logic signed [21:0] ytmp_q;
  logic signed [31:0] pos_q   [3];
  logic signed [15:0] front_q [3];
  logic signed [15:0] right_q [3];
  logic signed [15:0] up_q    [3];
  logic signed [31:0] cy_q, sy_q, cp_q, sp_q;
  logic signed [31:0] vin_q   [3];
  logic [31:0]        mag_q   [3];
  logic               neg_q   [3];
  logic signed [15:0] res_q   [3];
  logic [SUM_W-1:0]   sum_q;
  logic [LEN_W-1:0]   len_q;
  ecbu_out_t          out_q;
  logic               out_valid_q;

  logic [1:0]         kx;
  logic [1:0]         kh;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               cor_done, sqrt_done, div_done;
  logic signed [31:0] cor_cos, cor_sin;
  logic [LEN_W-1:0]   sqrt_root;
  logic [QUO_W-1:0]   div_quo;
  logic [QUO_W-1:0]   quo_cap;
  logic signed [15:0] quo_signed;
  logic signed [33:0] rot_t;
  logic signed [20:0] rot_delta;
  logic signed [21:0] yaw_sum;
  logic signed [21:0] pitch_diff;
  logic signed [32:0] scr_t;
  logic signed [30:0] scr_delta;
  logic               any_big, all_small, all_zero;
  ecbu_out_t          out_d;

  assign kx = k_q[1:0];
  assign kh = k_q[2:1];

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] clamp_pitch(input logic signed [21:0] v,
                                                     input logic [13:0] limit);
    logic signed [21:0] lim;
    lim = (limit > LIMIT_MAX) ? 22'(LIMIT_MAX) : 22'(limit);
    if (v > lim) begin
      return lim[15:0];
    end
    if (v < -lim) begin
      return 16'(-lim);
    end
    return v[15:0];
  endfunction

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ROT_X: begin
        mul_a = 32'(req_q.delta_x);
        mul_b = {16'b0, gain_q};
      end
      ST_ROT_Y: begin
        mul_a = 32'(req_q.delta_y);
        mul_b = {16'b0, gain_q};
      end
      ST_SCR_MUL: begin
        mul_a = 32'(front_q[kx]);
        mul_b = 32'(req_q.delta_y);
      end
      ST_FR_MUL: begin
        mul_a = k_q[0] ? sy_q : cy_q;
        mul_b = cp_q;
      end
      ST_SQ_MUL: begin
        mul_a = $signed(mag_q[kx]);
        mul_b = $signed(mag_q[kx]);
      end
      ST_UP_MUL: begin
        // up = right x front, two products per component
        case (k_q)
          3'd0: begin mul_a = 32'(right_q[1]); mul_b = 32'(front_q[2]); end
          3'd1: begin mul_a = 32'(right_q[2]); mul_b = 32'(front_q[1]); end
          3'd2: begin mul_a = 32'(right_q[2]); mul_b = 32'(front_q[0]); end
          3'd3: begin mul_a = 32'(right_q[0]); mul_b = 32'(front_q[2]); end
          3'd4: begin mul_a = 32'(right_q[0]); mul_b = 32'(front_q[1]); end
          default: begin mul_a = 32'(right_q[1]); mul_b = 32'(front_q[0]); end
        endcase
      end
      default: begin
      end
    endcase
  end

  ecbu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ecbu_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_COR_GO),
    .angle_i (cor_pitch_q ? pitch_q : yaw_q),
    .done_o  (cor_done),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin)
  );

  ecbu_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_SQRT_GO),
    .n_i     (sum_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  ecbu_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_DIV_GO),
    .mag_i   (mag_q[kx][NORM_W-1:0]),
    .len_i   (len_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // mouse delta: round half up of product / 2^13
  assign rot_t      = $signed(mul_p[33:0]) + 34'sd4096;
  assign rot_delta  = rot_t[33:13];
  assign yaw_sum    = 22'(yaw_q) + 22'(rot_delta);
  assign pitch_diff = 22'(pitch_q) - 22'(rot_delta);

  // scroll step: round half up of product / 4
  assign scr_t      = 33'($signed(mul_p[31:0])) + 33'sd2;
  assign scr_delta  = scr_t[32:2];

  // normalize range checks on the magnitudes
  assign any_big   = |{mag_q[0][31:24], mag_q[1][31:24], mag_q[2][31:24]};
  assign all_small = ~|{mag_q[0][31:23], mag_q[1][31:23], mag_q[2][31:23]};
  assign all_zero  = ~|{mag_q[0], mag_q[1], mag_q[2]};

  // cap at 1.0 and restore the sign
  assign quo_cap    = (div_quo > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14) : div_quo;
  assign quo_signed = neg_q[kx] ? -$signed(quo_cap) : $signed(quo_cap);

  always_comb begin
    out_d.front_x = front_q[0];
    out_d.front_y = front_q[1];
    out_d.front_z = front_q[2];
    out_d.right_x = right_q[0];
    out_d.right_y = right_q[1];
    out_d.right_z = right_q[2];
    out_d.up_x    = up_q[0];
    out_d.up_y    = up_q[1];
    out_d.up_z    = up_q[2];
    out_d.pos_x   = pos_q[0];
    out_d.pos_y   = pos_q[1];
    out_d.pos_z   = pos_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= SEL_FRONT;
      k_q         <= '0;
      cor_pitch_q <= 1'b0;
      deg_q       <= 1'b0;
      req_q       <= '0;
      gain_q      <= GAIN_RST;
      limit_q     <= LIMIT_RST;
      yaw_q       <= YAW_RST;
      pitch_q     <= '0;
      ytmp_q      <= '0;
      pos_q[0]    <= '0;
      pos_q[1]    <= POS_RST_Y;
      pos_q[2]    <= POS_RST_Z;
      front_q[0]  <= '0;
      front_q[1]  <= '0;
      front_q[2]  <= -ONE_Q14;
      right_q[0]  <= ONE_Q14;
      right_q[1]  <= '0;
      right_q[2]  <= '0;
      up_q[0]     <= '0;
      up_q[1]     <= ONE_Q14;
      up_q[2]     <= '0;
      cy_q        <= '0;
      sy_q        <= '0;
      cp_q        <= '0;
      sp_q        <= '0;
      for (int i = 0; i < 3; i++) begin
        vin_q[i] <= '0;
        mag_q[i] <= '0;
        neg_q[i] <= 1'b0;
        res_q[i] <= '0;
      end
      sum_q       <= '0;
      len_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MOUSE_GAIN:  gain_q  <= cfg_data_i;
          CFG_PITCH_LIMIT: limit_q <= cfg_data_i[13:0];
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            k_q   <= '0;
            case (in_data_i.action)
              ACT_ROTATE:  state_q <= ST_ROT_X;
              ACT_SCROLL:  state_q <= ST_SCR_MUL;
              ACT_MOVE:    state_q <= ST_MOVE;
              ACT_SET_YAW: begin
                ytmp_q  <= 22'(in_data_i.angle);
                state_q <= ST_WRAP;
              end
              ACT_SET_PITCH: begin
                pitch_q     <= clamp_pitch(22'(in_data_i.angle), limit_q);
                cor_pitch_q <= 1'b0;
                state_q     <= ST_COR_GO;
              end
              ACT_SET_POS: begin
                pos_q[0] <= in_data_i.vec_x;
                pos_q[1] <= in_data_i.vec_y;
                pos_q[2] <= in_data_i.vec_z;
                state_q  <= ST_DONE;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end

        ST_ROT_X: state_q <= ST_ROT_Y;

        ST_ROT_Y: begin
          ytmp_q  <= yaw_sum;
          state_q <= ST_ROT_P;
        end

        ST_ROT_P: begin
          pitch_q <= clamp_pitch(pitch_diff, limit_q);
          state_q <= ST_WRAP;
        end

        // one modulo-360 correction per cycle
        ST_WRAP: begin
          if (ytmp_q >= WRAP_HALF) begin
            ytmp_q <= ytmp_q - WRAP_FULL;
          end else if (ytmp_q < -WRAP_HALF) begin
            ytmp_q <= ytmp_q + WRAP_FULL;
          end else begin
            yaw_q       <= ytmp_q[15:0];
            cor_pitch_q <= 1'b0;
            state_q     <= ST_COR_GO;
          end
        end

        ST_SCR_MUL: state_q <= ST_SCR_ADD;

        ST_SCR_ADD: begin
          pos_q[kx] <= sat32(34'(pos_q[kx]) + 34'(scr_delta));
          if (k_q == 3'd2) begin
            state_q <= ST_DONE;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_SCR_MUL;
          end
        end

        ST_MOVE: begin
          pos_q[0] <= sat32(34'(pos_q[0]) + 34'(req_q.vec_x));
          pos_q[1] <= sat32(34'(pos_q[1]) + 34'(req_q.vec_y));
          pos_q[2] <= sat32(34'(pos_q[2]) + 34'(req_q.vec_z));
          state_q  <= ST_DONE;
        end

        ST_COR_GO: state_q <= ST_COR_WAIT;

        ST_COR_WAIT: begin
          if (cor_done) begin
            if (!cor_pitch_q) begin
              cy_q        <= cor_cos;
              sy_q        <= cor_sin;
              cor_pitch_q <= 1'b1;
              state_q     <= ST_COR_GO;
            end else begin
              cp_q    <= cor_cos;
              sp_q    <= cor_sin;
              k_q     <= '0;
              state_q <= ST_FR_MUL;
            end
          end
        end

        ST_FR_MUL: state_q <= ST_FR_LOAD;

        // raw front = (cy*cp, sp, sy*cp)
        ST_FR_LOAD: begin
          if (!k_q[0]) begin
            vin_q[0] <= mul_p[61:30];
            k_q      <= 3'd1;
            state_q  <= ST_FR_MUL;
          end else begin
            vin_q[1] <= sp_q;
            vin_q[2] <= mul_p[61:30];
            sel_q    <= SEL_FRONT;
            state_q  <= ST_N_ABS;
          end
        end

        ST_N_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vin_q[i][31];
            mag_q[i] <= vin_q[i][31] ? 32'(-vin_q[i]) : 32'(vin_q[i]);
          end
          deg_q   <= 1'b0;
          state_q <= ST_N_SHIFT;
        end

        // bring the largest magnitude into [2^23, 2^24), one bit a cycle
        ST_N_SHIFT: begin
          if (all_zero) begin
            deg_q   <= 1'b1;
            state_q <= ST_N_END;
          end else if (any_big) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] >> 1;
            end
          end else if (all_small) begin
            for (int i = 0; i < 3; i++) begin
              mag_q[i] <= mag_q[i] << 1;
            end
          end else begin
            k_q     <= '0;
            sum_q   <= '0;
            state_q <= ST_SQ_MUL;
          end
        end

        ST_SQ_MUL: state_q <= ST_SQ_ACC;

        ST_SQ_ACC: begin
          sum_q <= sum_q + SUM_W'(mul_p[47:0]);
          if (k_q == 3'd2) begin
            state_q <= ST_SQRT_GO;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_SQ_MUL;
          end
        end

        ST_SQRT_GO: state_q <= ST_SQRT_WAIT;

        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            len_q   <= sqrt_root;
            k_q     <= '0;
            state_q <= ST_DIV_GO;
          end
        end

        ST_DIV_GO: state_q <= ST_DIV_WAIT;

        ST_DIV_WAIT: begin
          if (div_done) begin
            res_q[kx] <= quo_signed;
            if (k_q == 3'd2) begin
              state_q <= ST_N_END;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_DIV_GO;
            end
          end
        end

        // a degenerate vector keeps its previous value
        ST_N_END: begin
          k_q <= '0;
          case (sel_q)
            SEL_FRONT: begin
              if (!deg_q) begin
                for (int i = 0; i < 3; i++) begin
                  front_q[i] <= res_q[i];
                end
              end
              state_q <= ST_R_LOAD;
            end
            SEL_RIGHT: begin
              if (!deg_q) begin
                for (int i = 0; i < 3; i++) begin
                  right_q[i] <= res_q[i];
                end
              end
              state_q <= ST_UP_MUL;
            end
            default: begin
              if (!deg_q) begin
                for (int i = 0; i < 3; i++) begin
                  up_q[i] <= res_q[i];
                end
              end
              state_q <= ST_DONE;
            end
          endcase
        end

        // front x world up = (-fz, 0, fx)
        ST_R_LOAD: begin
          vin_q[0] <= -32'(front_q[2]);
          vin_q[1] <= '0;
          vin_q[2] <= 32'(front_q[0]);
          sel_q    <= SEL_RIGHT;
          state_q  <= ST_N_ABS;
        end

        ST_UP_MUL: state_q <= ST_UP_ACC;

        ST_UP_ACC: begin
          if (!k_q[0]) begin
            vin_q[kh] <= $signed(mul_p[31:0]);
          end else begin
            vin_q[kh] <= vin_q[kh] - $signed(mul_p[31:0]);
          end
          if (k_q == 3'd5) begin
            sel_q   <= SEL_UP;
            state_q <= ST_N_ABS;
          end else begin
            k_q     <= k_q + 3'd1;
            state_q <= ST_UP_MUL;
          end
        end

        // hold until the output register is free
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= out_d;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Checks the fly camera basis update against a bit-accurate behavioral
// predictor: directed corner actions, then random action streams under
// several idling phases and configuration settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ecbu_pkg::*;

  localparam int unsigned STEPS     = 16;
  localparam int          LIMIT_CYC = 2000000;
  localparam int          DRAIN_CYC = 600;

  // predicted camera state and the queue of expected views
  class camera_scoreboard;
    int          gain;
    int          limit;
    int          yaw;
    int          pitch;
    int          pos [3];
    int          fv [3];
    int          rv [3];
    int          uv [3];
    ecbu_out_t   view_q [$];
    int          errors;
    int          checked;

    function void reset_state();
      gain = GAIN_RST; limit = LIMIT_RST; yaw = -11520; pitch = 0;
      pos = '{0, 655360, 5242880};
      fv = '{0, 0, -16384}; rv = '{16384, 0, 0}; uv = '{0, 16384, 0};
    endfunction

    // arithmetic shift is a floor shift on longint
    function longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function int sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    function int wrap(longint v);
      longint r;
      r = (v + 23040) % 46080;
      if (r < 0) r += 46080;
      return int'(r - 23040);
    endfunction

    function int clampp(longint v);
      longint l;
      l = (limit > 11520) ? 11520 : limit;
      if (v > l) return int'(l);
      if (v < -l) return int'(-l);
      return int'(v);
    endfunction

    function void sin_cos(int ang, output longint c, output longint s);
      longint a, x, y, z, dx, dy;
      bit flip;
      a = ang; flip = 0; x = 652032874; y = 0;
      if (a > 11520) begin
        a -= 23040; flip = 1;
      end else if (a < -11520) begin
        a += 23040; flip = 1;
      end
      z = a * 512;
      for (int i = 0; i < STEPS && i < 24; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(atan_val(i[4:0]));
        end else begin
          x += dx; y -= dy; z += longint'(atan_val(i[4:0]));
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n -= r + b; r = (r >> 1) + b;
        end else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    // unit vector in Q1.14, returns 0 and leaves o alone when all zero
    function bit unit(longint v [3], ref int o [3]);
      longint unsigned m [3];
      longint unsigned mx, sum, len, q;
      bit ng [3];
      mx = 0; sum = 0;
      for (int k = 0; k < 3; k++) begin
        ng[k] = v[k] < 0;
        m[k] = ng[k] ? -v[k] : v[k];
        if (m[k] > mx) mx = m[k];
      end
      if (mx == 0) return 0;
      while (mx >= (64'd1 << 24)) begin
        for (int k = 0; k < 3; k++) m[k] >>= 1;
        mx >>= 1;
      end
      while (mx < (64'd1 << 23)) begin
        for (int k = 0; k < 3; k++) m[k] <<= 1;
        mx <<= 1;
      end
      for (int k = 0; k < 3; k++) sum += m[k] * m[k];
      len = root(sum);
      for (int k = 0; k < 3; k++) begin
        q = (m[k] * 32768 + len) / (2 * len);
        if (q > 16384) q = 16384;
        o[k] = ng[k] ? -int'(q) : int'(q);
      end
      return 1;
    endfunction

    function void rebuild();
      longint cy, sy, cp, sp;
      longint f [3], r [3], u [3];
      sin_cos(yaw, cy, sy);
      sin_cos(pitch, cp, sp);
      f = '{(cy * cp) >>> 30, sp, (sy * cp) >>> 30};
      void'(unit(f, fv));
      r = '{-fv[2], 0, fv[0]};
      void'(unit(r, rv));
      u[0] = longint'(rv[1]) * fv[2] - longint'(rv[2]) * fv[1];
      u[1] = longint'(rv[2]) * fv[0] - longint'(rv[0]) * fv[2];
      u[2] = longint'(rv[0]) * fv[1] - longint'(rv[1]) * fv[0];
      void'(unit(u, uv));
    endfunction

    function void note_action(ecbu_in_t t);
      ecbu_out_t e;
      longint vv [3];
      vv = '{t.vec_x, t.vec_y, t.vec_z};
      case (t.action)
        ACT_ROTATE: begin
          yaw = wrap(longint'(yaw) + round_sh(longint'(t.delta_x) * gain, 13));
          pitch = clampp(longint'(pitch) - round_sh(longint'(t.delta_y) * gain, 13));
          rebuild();
        end
        ACT_SCROLL:
          for (int k = 0; k < 3; k++)
            pos[k] = sat(longint'(pos[k]) + round_sh(longint'(fv[k]) * t.delta_y, 2));
        ACT_MOVE:
          for (int k = 0; k < 3; k++) pos[k] = sat(longint'(pos[k]) + vv[k]);
        ACT_SET_YAW: begin
          yaw = wrap(t.angle);
          rebuild();
        end
        ACT_SET_PITCH: begin
          pitch = clampp(t.angle);
          rebuild();
        end
        ACT_SET_POS:
          for (int k = 0; k < 3; k++) pos[k] = int'(vv[k]);
        default: ;
      endcase
      e.front_x = fv[0]; e.front_y = fv[1]; e.front_z = fv[2];
      e.right_x = rv[0]; e.right_y = rv[1]; e.right_z = rv[2];
      e.up_x = uv[0]; e.up_y = uv[1]; e.up_z = uv[2];
      e.pos_x = pos[0]; e.pos_y = pos[1]; e.pos_z = pos[2];
      view_q.push_back(e);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        $error("%s mismatch: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_view(ecbu_out_t a);
      ecbu_out_t e;
      if (view_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = view_q.pop_front();
      checked++;
      cmp("front_x", e.front_x, a.front_x);
      cmp("front_y", e.front_y, a.front_y);
      cmp("front_z", e.front_z, a.front_z);
      cmp("right_x", e.right_x, a.right_x);
      cmp("right_y", e.right_y, a.right_y);
      cmp("right_z", e.right_z, a.right_z);
      cmp("up_x", e.up_x, a.up_x);
      cmp("up_y", e.up_y, a.up_y);
      cmp("up_z", e.up_z, a.up_z);
      cmp("pos_x", e.pos_x, a.pos_x);
      cmp("pos_y", e.pos_y, a.pos_y);
      cmp("pos_z", e.pos_z, a.pos_z);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  ecbu_cfg_e cfg_idx;
  logic [15:0] cfg_data;
  logic      in_valid;
  logic      in_ready;
  ecbu_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ecbu_out_t out_data;

  camera_scoreboard sb;
  int        send_idle_pct;   // sender gap chance in percent
  int        recv_stall_pct;  // receiver stall chance in percent
  bit        hold_recv;       // long receiver hold-off
  int        cycles;
  int        sent;

  euler_camera_basis_update #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus the long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_view(out_data);
      out_ready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(ecbu_cfg_e idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MOUSE_GAIN) sb.gain = val;
    else sb.limit = val[13:0];
  endtask

  // one transaction, with an optional random gap before it; valid stays
  // high after acceptance so that back-to-back transactions need no gap
  task automatic send_action(ecbu_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (!in_ready);
    sb.note_action(t);
    sent++;
  endtask

  task automatic wait_drained();
    while (sb.view_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic ecbu_in_t make_action(logic [2:0] act);
    ecbu_in_t t;
    t.action = act;
    t.delta_x = $urandom; t.delta_y = $urandom; t.angle = $urandom;
    t.vec_x = $urandom; t.vec_y = $urandom; t.vec_z = $urandom;
    case ($urandom_range(3))
      0: begin
        // small mouse moves, from -200 to 200 on each axis
        t.delta_x = $signed($urandom_range(400)) - 200;
        t.delta_y = $signed($urandom_range(400)) - 200;
      end
      1: t.angle = $signed($urandom_range(30000)) - 15000;
      2: begin
        t.vec_x = $signed($urandom_range(200000)) - 100000;
        t.vec_y = $signed($urandom_range(200000)) - 100000;
      end
      default: ;
    endcase
    return t;
  endfunction

  task automatic random_phase(int count);
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      // unused codes now and then
      act = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_action(make_action(act));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    ecbu_in_t t;
    sb = new();
    sb.reset_state();
    rst_n = 1'b0; cfg_we = 1'b0; cfg_idx = CFG_MOUSE_GAIN; cfg_data = '0;
    in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_recv = 1'b0;
    cycles = 0; sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset configuration
    t = '0;
    t.action = ACT_MOVE; send_action(t);
    t.action = 3'd6; send_action(t);
    t.action = 3'd7; t.delta_x = 16'h7fff; send_action(t);
    t = '0; t.action = ACT_SET_PITCH; t.angle = 16'sh7fff; send_action(t);
    t.angle = -16'sh8000; send_action(t);
    t.action = ACT_SET_YAW; t.angle = 16'sh7fff; send_action(t);
    t.angle = -16'sh8000; send_action(t);
    t.angle = 16'sd11520; send_action(t);
    t.angle = -16'sd11521; send_action(t);
    t.angle = 16'sd23040; send_action(t);
    t = '0; t.action = ACT_ROTATE; t.delta_x = 16'sh7fff; t.delta_y = -16'sh8000;
    send_action(t);
    t.delta_x = -16'sh8000; t.delta_y = 16'sh7fff; send_action(t);
    t.delta_x = 16'sd1; t.delta_y = -16'sd1; send_action(t);
    t = '0; t.action = ACT_SCROLL; t.delta_y = 16'sh7fff; send_action(t);
    t.delta_y = -16'sh8000; send_action(t);
    t = '0; t.action = ACT_SET_POS; t.vec_x = 32'sh7fffffff; t.vec_y = 32'sh80000000;
    t.vec_z = 32'sh7fff0000; send_action(t);
    t.action = ACT_MOVE; send_action(t);
    t.vec_x = 32'sh80000000; t.vec_y = 32'sh7fffffff; send_action(t);
    t.vec_x = -1; t.vec_y = -1; t.vec_z = -1; send_action(t);
    t.action = ACT_SET_POS; t.vec_x = 0; t.vec_y = 0; t.vec_z = 0; send_action(t);
    in_valid <= 1'b0;
    wait_drained();

    // straight up: right stays put
    write_reg(CFG_PITCH_LIMIT, 14'd11520);
    t = '0; t.action = ACT_SET_PITCH; t.angle = 16'sd11520; send_action(t);
    t.angle = -16'sd11520; send_action(t);
    in_valid <= 1'b0;
    wait_drained();

    // limit above 90 degrees and max gain, then lowered limit below stored pitch
    write_reg(CFG_PITCH_LIMIT, 14'h3fff);
    write_reg(CFG_MOUSE_GAIN, 16'hffff);
    t = '0; t.action = ACT_SET_PITCH; t.angle = 16'sd9000; send_action(t);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(CFG_PITCH_LIMIT, 14'd1000);
    t = '0; t.action = ACT_SET_YAW; t.angle = 16'sd100; send_action(t);
    t.action = ACT_ROTATE; send_action(t);
    in_valid <= 1'b0;
    wait_drained();

    // random phases over idling modes and settings
    write_reg(CFG_MOUSE_GAIN, GAIN_RST);
    write_reg(CFG_PITCH_LIMIT, LIMIT_RST);
    random_phase(90);
    wait_drained();
    send_idle_pct = 53;
    write_reg(CFG_MOUSE_GAIN, 16'd0);
    write_reg(CFG_PITCH_LIMIT, 14'd0);
    random_phase(70);
    wait_drained();
    send_idle_pct = 0; recv_stall_pct = 53;
    write_reg(CFG_MOUSE_GAIN, 16'hffff);
    write_reg(CFG_PITCH_LIMIT, 14'd11520);
    random_phase(80);
    wait_drained();
    send_idle_pct = 6; recv_stall_pct = 6;
    write_reg(CFG_MOUSE_GAIN, 16'd30000);
    write_reg(CFG_PITCH_LIMIT, 14'd5000);
    random_phase(80);
    wait_drained();

    // receiver holds off while the sender keeps offering
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_recv = 1'b1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_phase(20);
    join
    wait_drained();
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d actions, %0d results checked, gains 0..65535, limits 0..16383",
             sent, sb.checked);
    if (sb.errors == 0 && sb.view_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
